// File: src/sha256_stream_hasher_unit_defines.svh
// Assertion macros shared by the hasher RTL
`ifndef SHA256_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_STREAM_HASHER_UNIT_DEFINES_SVH

// same-cycle implication
`define SHS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hasher assertion failed");

// next-cycle implication
`define SHS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hasher assertion failed");

`endif

// File: src/sha256sh_pkg.sv
// Types, constants and tables of the SHA-256 stream hasher
`default_nettype none

package sha256sh_pkg;

	localparam logic [7:0] PadMark = 8'h80;
	localparam logic [5:0] LenFill = 6'd56;

	typedef logic [31:0] word_t;
	typedef word_t [7:0] vars_t;
	typedef word_t [15:0] window_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       finish;
	} in_item_t;

	typedef struct packed {
		word_t      digest_word;
		logic [2:0] word_index;
		logic       last_word;
	} out_item_t;

	function automatic word_t round_k(input logic [5:0] t);
		word_t k;
		case (t)
			6'd0:  k = 32'h428a2f98;
			6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;
			6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;
			6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;
			6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;
			6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;
			6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;
			6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;
			6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;
			6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;
			6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;
			6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;
			6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;
			6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;
			6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;
			6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;
			6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;
			6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;
			6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;
			6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;
			6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;
			6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;
			6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;
			6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t init_h(input logic [2:0] i);
		word_t h;
		case (i)
			3'd0: h = 32'h6a09e667;
			3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372;
			3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f;
			3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab;
			default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

endpackage

`default_nettype wire

// File: src/sha256_stream_hasher_unit.sv
// Top level of the SHA-256 stream hasher
// A message byte is taken while the block is idle and packed into a 16-word block memory. The
// 64th byte of a block starts a compression (read the hash memory into the working variables,
// 64 rounds at one per cycle, add back into the hash memory) during which input is stalled.
// Finish feeds the padding bytes through the same byte path, one per cycle outside compressions
// but for one gap before the length field, and they start one or two compressions; the final
// add emits the eight digest words, one per cycle while out_stall stays low.
`default_nettype none
`include "sha256_stream_hasher_unit_defines.svh"

module sha256_stream_hasher_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  sha256sh_pkg::in_item_t in_item,
	output logic                   out_valid,
	input  logic                   out_stall,
	output sha256sh_pkg::out_item_t out_item
);
	import sha256sh_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_PAD, S_LOAD, S_ROUND, S_ADD} state_t;
	typedef enum logic [1:0] {PH_MARK, PH_ZERO, PH_LEN} phase_t;

	state_t     state_q;
	phase_t     pph_q;
	logic [5:0] fill_q;
	logic [60:0] len_q;
	logic [63:0] lsr_q;
	logic [2:0] lcnt_q;
	logic [23:0] word_q;
	logic       pad_q;
	logic       final_q;
	logic [3:0] cnt_q;
	logic [5:0] rcnt_q;
	logic [7:0] hv_q;
	logic       out_valid_q;
	out_item_t  out_q;

	vars_t      v_q;
	window_t    win_q;
	word_t      bmem [16];
	word_t      hmem [8];
	word_t      bm_rd_q;
	word_t      h_rd_q;
	logic       h_rdv_q;

	logic       in_take, byte_en, blk_full, out_free, add_go, add_wr, h_rd_en;
	logic [7:0] byte_val;
	logic [3:0] bm_addr;
	logic [2:0] h_idx;
	word_t      h_cur, h_sum, wt;
	vars_t      v_next;

	assign in_stall  = (state_q != S_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		byte_en  = 1'b0;
		byte_val = in_item.data_byte;
		case (state_q)
			S_IDLE: begin
				byte_en = in_take && in_item.byte_valid;
			end
			S_PAD: begin
				case (pph_q)
					PH_MARK: begin
						byte_en  = 1'b1;
						byte_val = PadMark;
					end
					PH_ZERO: begin
						byte_en  = (fill_q != LenFill);
						byte_val = '0;
					end
					PH_LEN: begin
						byte_en  = 1'b1;
						byte_val = lsr_q[63:56];
					end
					default: byte_en = 1'b0;
				endcase
			end
			default: byte_en = 1'b0;
		endcase
	end

	assign blk_full = byte_en && (&fill_q);
	assign out_free = !out_valid_q || !out_stall;
	assign add_go   = !final_q || out_free;
	assign add_wr   = (state_q == S_ADD) && (cnt_q != 4'd0) && add_go;
	assign h_rd_en  = ((state_q == S_LOAD) || ((state_q == S_ADD) && (cnt_q == 4'd0 || add_go)))
		&& !cnt_q[3];
	assign h_idx    = 3'(cnt_q - 4'd1);
	assign h_cur    = h_rdv_q ? h_rd_q : init_h(h_idx);
	assign h_sum    = h_cur + v_q[0];
	assign bm_addr  = (state_q == S_ROUND) ? rcnt_q[3:0] + 4'd1 : '0;

	sha256sh_round u_round (
		.v        (v_q),
		.win      (win_q),
		.buf_word (bm_rd_q),
		.use_buf  (rcnt_q[5:4] == 2'b00),
		.k        (round_k(rcnt_q)),
		.wt       (wt),
		.v_next   (v_next)
	);

	always_ff @(posedge clk) begin
		if (byte_en && fill_q[1:0] == 2'b11) begin
			bmem[fill_q[5:2]] <= {word_q, byte_val};
		end
		bm_rd_q <= bmem[bm_addr];
	end

	always_ff @(posedge clk) begin
		if (add_wr && !final_q) begin
			hmem[h_idx] <= h_sum;
		end
		if (h_rd_en) begin
			h_rd_q  <= hmem[cnt_q[2:0]];
			h_rdv_q <= hv_q[cnt_q[2:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (byte_en) begin
			word_q <= {word_q[15:0], byte_val};
		end
		case (state_q)
			S_LOAD: begin
				if (cnt_q != 4'd0) begin
					v_q <= {h_cur, v_q[7:1]};
				end
			end
			S_ROUND: begin
				v_q   <= v_next;
				win_q <= {wt, win_q[15:1]};
			end
			S_ADD: begin
				if (add_wr) begin
					v_q <= {v_q[0], v_q[7:1]};
				end
			end
			default: v_q <= v_q;
		endcase
		if (add_wr && final_q) begin
			out_q.digest_word <= h_sum;
			out_q.word_index  <= h_idx;
			out_q.last_word   <= (h_idx == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pph_q       <= PH_MARK;
			fill_q      <= '0;
			len_q       <= '0;
			lsr_q       <= '0;
			lcnt_q      <= '0;
			pad_q       <= 1'b0;
			final_q     <= 1'b0;
			cnt_q       <= '0;
			rcnt_q      <= '0;
			hv_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (in_item.byte_valid) begin
							len_q <= len_q + 61'd1;
						end
						if (in_item.finish) begin
							lsr_q   <= {len_q + 61'(in_item.byte_valid), 3'b000};
							len_q   <= '0;
							pad_q   <= 1'b1;
							pph_q   <= PH_MARK;
							lcnt_q  <= '0;
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					case (pph_q)
						PH_MARK: pph_q <= PH_ZERO;
						PH_ZERO: begin
							if (fill_q == LenFill) begin
								pph_q <= PH_LEN;
							end
						end
						PH_LEN: begin
							lsr_q  <= {lsr_q[55:0], 8'h00};
							lcnt_q <= lcnt_q + 3'd1;
							if (lcnt_q == 3'd7) begin
								final_q <= 1'b1;
							end
						end
						default: pph_q <= PH_MARK;
					endcase
				end
				S_LOAD: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd8) begin
						state_q <= S_ROUND;
						rcnt_q  <= '0;
					end
				end
				S_ROUND: begin
					rcnt_q <= rcnt_q + 6'd1;
					if (rcnt_q == 6'd63) begin
						state_q <= S_ADD;
						cnt_q   <= '0;
					end
				end
				S_ADD: begin
					if (cnt_q == 4'd0 || add_go) begin
						if (cnt_q == 4'd8) begin
							if (final_q || !pad_q) begin
								state_q <= S_IDLE;
							end else begin
								state_q <= S_PAD;
							end
							final_q <= 1'b0;
							if (final_q) begin
								pad_q <= 1'b0;
							end
						end else begin
							cnt_q <= cnt_q + 4'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (byte_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (blk_full) begin
				state_q <= S_LOAD;
				cnt_q   <= '0;
			end

			if (add_wr) begin
				hv_q[h_idx] <= !final_q;
			end

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (add_wr && final_q) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	`SHS_ASSERT_IMP(a_idle_not_final, clk, arst_n, state_q == S_IDLE, !final_q)
	`SHS_ASSERT_NXT(a_rounds_to_add, clk, arst_n,
		state_q == S_ROUND && rcnt_q == 6'd63, state_q == S_ADD && cnt_q == 4'd0)
	`SHS_ASSERT_IMP(a_last_word, clk, arst_n,
		out_valid_q, out_q.last_word == (out_q.word_index == 3'd7))
	`SHS_ASSERT_NXT(a_emit_hold, clk, arst_n,
		state_q == S_ADD && final_q && cnt_q != 4'd0 && out_valid_q && out_stall, $stable(cnt_q))
	`SHS_ASSERT_IMP(a_len_fill, clk, arst_n,
		state_q == S_PAD && pph_q == PH_LEN, fill_q == {3'b111, lcnt_q})

endmodule

`default_nettype wire

// File: src/sha256sh_round.sv
// One SHA-256 round with its message schedule expansion
`default_nettype none

module sha256sh_round (
	input  sha256sh_pkg::vars_t   v,
	input  sha256sh_pkg::window_t win,
	input  sha256sh_pkg::word_t   buf_word,
	input  logic                  use_buf,
	input  sha256sh_pkg::word_t   k,
	output sha256sh_pkg::word_t   wt,
	output sha256sh_pkg::vars_t   v_next
);
	import sha256sh_pkg::*;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	word_t g0, g1, s0, s1, ch, mj, t1, t2;

	always_comb begin
		g0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
		g1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
		wt = use_buf ? buf_word : win[0] + g0 + win[9] + g1;
		s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
		ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
		t1 = v[7] + s1 + ch + k + wt;
		s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
		mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
		t2 = s0 + mj;
		v_next[0] = t1 + t2;
		v_next[1] = v[0];
		v_next[2] = v[1];
		v_next[3] = v[2];
		v_next[4] = v[3] + t1;
		v_next[5] = v[4];
		v_next[6] = v[5];
		v_next[7] = v[6];
	end

endmodule

`default_nettype wire

// File: verif/sha256_stream_hasher_unit_test.sv
// Self-checking testbench for the SHA-256 stream hasher: byte streams in, digest words checked
`timescale 1ns / 1ps

module sha256_stream_hasher_unit_test;

	import sha256sh_pkg::*;

	localparam int CLK_PERIOD   = 4;
	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int HOLD_CYCLES  = 1000;
	localparam int TAIL_CYCLES  = 300;
	localparam int REPORT_CAP   = 100;
	localparam int PHASE_ITEMS  = 25;
	localparam int NOISE_PCT    = 8;
	localparam int LEN_FIELD_AT = 56;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [0:63][31:0] ROUND_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [0:7][31:0] IV_WORDS = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_item;

	logic [0:7][31:0] hash_acc;
	logic [7:0]       blk_bytes [64];
	logic [5:0]       blk_fill;
	logic [60:0]      msg_len;
	out_item_t        digest_due [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int mismatches = 0;
	int msg_items = 0;
	int idle_items = 0;
	int digests_seen = 0;
	int longest_msg = 0;

	sha256_stream_hasher_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic void compress_held_block();
		logic [31:0] sched [64];
		logic [31:0] va, vb, vc, vd, ve, vf, vg, vh, t1, t2;
		for (int t = 0; t < 16; t++)
			sched[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
		for (int t = 16; t < 64; t++)
			sched[t] = sched[t-16] + sched[t-7]
				+ (rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3))
				+ (rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10));
		{va, vb, vc, vd, ve, vf, vg, vh} = hash_acc;
		for (int t = 0; t < 64; t++) begin
			t1 = vh + (rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25))
				+ ((ve & vf) ^ (~ve & vg)) + ROUND_K[t] + sched[t];
			t2 = (rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22))
				+ ((va & vb) ^ (va & vc) ^ (vb & vc));
			vh = vg;
			vg = vf;
			vf = ve;
			ve = vd + t1;
			vd = vc;
			vc = vb;
			vb = va;
			va = t1 + t2;
		end
		hash_acc[0] += va;
		hash_acc[1] += vb;
		hash_acc[2] += vc;
		hash_acc[3] += vd;
		hash_acc[4] += ve;
		hash_acc[5] += vf;
		hash_acc[6] += vg;
		hash_acc[7] += vh;
	endfunction

	function automatic void hash_step(input in_item_t it);
		logic [63:0] bit_len;
		int          pos;
		out_item_t   word;
		if (it.byte_valid) begin
			blk_bytes[blk_fill] = it.data_byte;
			blk_fill++;
			msg_len++;
			if (blk_fill == 6'd0)
				compress_held_block();
		end
		if (it.finish) begin
			bit_len = {msg_len, 3'b000};
			if (int'(msg_len) > longest_msg)
				longest_msg = int'(msg_len);
			blk_bytes[blk_fill] = PAD_BYTE;
			pos = blk_fill + 1;
			// no room for the length field: close this block and open a fresh one
			if (pos > LEN_FIELD_AT) begin
				for (int j = pos; j < 64; j++)
					blk_bytes[j] = 8'h00;
				compress_held_block();
				pos = 0;
			end
			for (int j = pos; j < LEN_FIELD_AT; j++)
				blk_bytes[j] = 8'h00;
			for (int j = 0; j < 8; j++)
				blk_bytes[63 - j] = bit_len[8*j +: 8];
			compress_held_block();
			for (int j = 0; j < 8; j++) begin
				word.digest_word = hash_acc[j];
				word.word_index = 3'(j);
				word.last_word = (j == 7);
				digest_due.push_back(word);
			end
			hash_acc = IV_WORDS;
			blk_fill = '0;
			msg_len = '0;
		end
	endfunction

	// entered and left at a falling edge
	task automatic send_item(input in_item_t item);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_item <= item;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		hash_step(item);
		if (item.byte_valid || item.finish)
			msg_items++;
		else
			idle_items++;
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [7:0] data, input logic bv, input logic fin);
		in_item_t it;
		it.data_byte = data;
		it.byte_valid = bv;
		it.finish = fin;
		send_item(it);
	endtask

	task automatic send_message(input int len, input bit joined, input int noise_pct);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < noise_pct)
				send_fields(8'($urandom_range(255)), 1'b0, 1'b0);
			send_fields(8'($urandom_range(255)), 1'b1, joined && (i == len - 1));
		end
		if (!joined || len == 0)
			send_fields(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (digest_due.size() != 0)
			@(negedge clk);
	endtask

	function automatic int pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(8);
		if (r < 95)
			return $urandom_range(40, 9);
		return $urandom_range(72, 54);
	endfunction

	task automatic test_known_vectors();
		send_idle_pct = 0;
		stall_pct = 0;
		send_fields(8'hff, 1'b0, 1'b0);
		send_fields(8'h00, 1'b0, 1'b1);
		send_fields(8'h61, 1'b1, 1'b0);
		send_fields(8'h62, 1'b1, 1'b0);
		send_fields(8'h63, 1'b1, 1'b1);
		send_fields(8'h00, 1'b1, 1'b0);
		send_fields(8'hff, 1'b1, 1'b0);
		send_fields(8'h5a, 1'b0, 1'b0);
		send_fields(8'ha5, 1'b0, 1'b1);
		send_fields(8'hff, 1'b1, 1'b1);
		send_fields(8'hff, 1'b0, 1'b1);
		wait_drained();
	endtask

	task automatic test_block_boundaries();
		send_message(55, 1'b1, 0);
		send_message(56, 1'b0, 0);
		send_message(63, 1'b1, 0);
		send_message(64, 1'b0, 0);
		wait_drained();
	endtask

	task automatic test_random_messages(input int idle_pct, input int stall_chance);
		int start;
		start = msg_items;
		send_idle_pct = idle_pct;
		stall_pct = stall_chance;
		while (msg_items - start < PHASE_ITEMS)
			send_message(pick_length(), 1'($urandom_range(1)), NOISE_PCT);
		wait_drained();
	endtask

	// hold the output long enough for the block to back up onto its input
	task automatic test_output_hold();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_requests++;
		repeat (5)
			send_message($urandom_range(6), 1'($urandom_range(1)), 0);
		wait_drained();
	endtask

	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (digest_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_CAP)
					$display("%0t: unexpected digest word: expected none, got %h idx %0d last %0b",
						$time, out_item.digest_word, out_item.word_index, out_item.last_word);
			end else begin
				want = digest_due.pop_front();
				if (out_item.digest_word !== want.digest_word) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$display("%0t: digest_word expected %h, got %h (index %0d)",
							$time, want.digest_word, out_item.digest_word, want.word_index);
				end
				if (out_item.word_index !== want.word_index) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$display("%0t: word_index expected %0d, got %0d",
							$time, want.word_index, out_item.word_index);
				end
				if (out_item.last_word !== want.last_word) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$display("%0t: last_word expected %0b, got %0b",
							$time, want.last_word, out_item.last_word);
				end
				if (want.last_word)
					digests_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run timed out with %0d digest words outstanding",
				$time, digest_due.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		hash_acc = IV_WORDS;
		blk_fill = '0;
		msg_len = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_known_vectors();
		test_block_boundaries();
		test_random_messages(0, 0);
		test_random_messages(64, 0);
		test_random_messages(0, 64);
		test_random_messages(34, 34);
		test_output_hold();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Hashed %0d message transfers plus %0d idle transfers into %0d digests, longest %0d bytes",
			msg_items, idle_items, digests_seen, longest_msg);
		$display("Traffic mixes: free-running, sender gaps, receiver stalls, both, and a %0d-cycle hold",
			HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d field mismatches", mismatches);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/sha256sh_pkg.sv
src/sha256sh_round.sv
src/sha256_stream_hasher_unit.sv
verif/sha256_stream_hasher_unit_test.sv
